// ===== rtl/core/mtfl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtfl_pkg: move-to-front list shared definitions
// Field widths, request codes, sequencer states and the control/status bundles
// of a list cell.
// ----------------------------------------------------------------------------
package mtfl_pkg;

  localparam int unsigned KEY_W   = 50;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned COUNT_W = 7;

  // request codes carried in func
  localparam logic FUNC_TOUCH = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_e;

  // Per-cell control, driven by the top level.
  typedef struct packed {
    logic look;   // register compare and rank-select results
    logic upd;    // apply a touch this cycle
    logic shift;  // take the upper neighbor's entry when upd is set
  } cell_ctrl_t;

  // Per-cell status, registered during look.
  typedef struct packed {
    logic match;  // cell holds the touched key
    logic hit;    // cell is the occupied entry at the requested rank
  } cell_stat_t;

endpackage

// ===== rtl/core/mtfl_in_if.sv =====
// ----------------------------------------------------------------------------
// mtfl_in_if: request channel
// Valid/ready channel that carries one touch or read request per beat.
// ----------------------------------------------------------------------------
interface mtfl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [mtfl_pkg::KEY_W-1:0]    name_key;
  logic [mtfl_pkg::RANK_W-1:0]   rank;

  modport source (output valid, output func, output name_key, output rank, input ready);
  modport sink   (input valid, input func, input name_key, input rank, output ready);
endinterface

// ===== rtl/core/mtfl_out_if.sv =====
// ----------------------------------------------------------------------------
// mtfl_out_if: result channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface mtfl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          was_present;
  logic [mtfl_pkg::RANK_W-1:0]   old_rank;
  logic                          evicted;
  logic [mtfl_pkg::KEY_W-1:0]    key_out;
  logic                          read_valid;
  logic [mtfl_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output was_present, output old_rank, output evicted,
                  output key_out, output read_valid, output entry_count, input ready);
  modport sink   (input valid, input was_present, input old_rank, input evicted,
                  input key_out, input read_valid, input entry_count, output ready);
endinterface

// ===== rtl/core/mtfl_cell.sv =====
// ----------------------------------------------------------------------------
// mtfl_cell: one rank of the recency list
// Holds a key and its used bit, compares against the broadcast key, flags the
// requested rank, and on a touch takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module mtfl_cell #(
  parameter int unsigned KW  = 50,
  parameter int unsigned IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mtfl_pkg::cell_ctrl_t         ctrl_i,
  input  logic [KW-1:0]                cmp_key_i,
  input  logic [mtfl_pkg::RANK_W-1:0]  rank_i,
  input  logic [KW-1:0]                prev_key_i,
  input  logic                         prev_used_i,
  output logic [KW-1:0]                key_o,
  output logic                         used_o,
  output mtfl_pkg::cell_stat_t         stat_o,
  output logic [KW-1:0]                rd_key_o
);

  logic [KW-1:0]        key_q;
  logic                 used_q;
  mtfl_pkg::cell_stat_t stat_q;
  mtfl_pkg::cell_stat_t stat_d;

  always_comb begin
    stat_d.match = used_q && (key_q == cmp_key_i);
    stat_d.hit   = used_q && (int'(rank_i) == int'(IDX));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      stat_q <= '0;
    end else begin
      if (ctrl_i.look) begin
        stat_q <= stat_d;
      end
      if (ctrl_i.upd && ctrl_i.shift) begin
        used_q <= prev_used_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd && ctrl_i.shift) begin
      key_q <= prev_key_i;
    end
  end

  assign key_o    = key_q;
  assign used_o   = used_q;
  assign stat_o   = stat_q;
  assign rd_key_o = stat_q.hit ? key_q : '0;

endmodule

// ===== rtl/core/move_to_front_recency_list_unit.sv =====
// ----------------------------------------------------------------------------
// move_to_front_recency_list_unit: move-to-front recency list
// Steps: accept, compare, update; the result is registered on the update.
// A new request is taken only after the compare pass over the cell row and
// the shift/update pass; a waiting result stalls the update.
// Reset clears the used bits and entry count at once; no clearing pass.
// ----------------------------------------------------------------------------
module move_to_front_recency_list_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned NAME_CHARS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtfl_in_if.sink    in_i,
  mtfl_out_if.source out_o
);

  localparam int unsigned KW    = (5 * NAME_CHARS < mtfl_pkg::KEY_W) ?
                                  5 * NAME_CHARS : mtfl_pkg::KEY_W;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  mtfl_pkg::state_e st_q, st_d;

  logic                        func_q;
  logic [KW-1:0]               key_q;
  logic [mtfl_pkg::RANK_W-1:0] rank_q;
  logic [CNT_W-1:0]            count_q;

  logic                        in_ready;
  logic                        out_free;
  logic                        apply_fire;
  logic                        look;
  logic                        upd;

  logic [KW-1:0]               key_w    [CAPACITY];
  logic [KW-1:0]               rd_key_w [CAPACITY];
  logic [CAPACITY-1:0]         used_w;
  logic [CAPACITY-1:0]         match_w;
  logic [CAPACITY-1:0]         hit_w;
  logic [CAPACITY-1:0]         shift_w;
  mtfl_pkg::cell_stat_t        stat_w   [CAPACITY];

  logic [IDX_W-1:0]            pos;
  logic                        found;
  logic                        full;
  logic [KW-1:0]               rd_key;

  logic                        out_valid_q, out_valid_d;

  // ---------------- sequencer ----------------
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mtfl_pkg::ST_IDLE:  if (in_i.valid) st_d = mtfl_pkg::ST_LOOK;
      mtfl_pkg::ST_LOOK:  st_d = mtfl_pkg::ST_APPLY;
      mtfl_pkg::ST_APPLY: if (out_free) st_d = mtfl_pkg::ST_IDLE;
      default:            st_d = mtfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    look       = 1'b0;
    apply_fire = 1'b0;
    unique case (st_q)
      mtfl_pkg::ST_IDLE:  in_ready   = 1'b1;
      mtfl_pkg::ST_LOOK:  look       = 1'b1;
      mtfl_pkg::ST_APPLY: apply_fire = out_free;
      default:            in_ready   = 1'b0;
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign upd      = apply_fire && (func_q == mtfl_pkg::FUNC_TOUCH);
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mtfl_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      func_q <= in_i.func;
      key_q  <= in_i.name_key[KW-1:0];
      rank_q <= in_i.rank;
    end
  end

  // ---------------- cell row ----------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mtfl_pkg::cell_ctrl_t ctrl;
    logic [KW-1:0]        prev_key;
    logic                 prev_used;

    assign ctrl.look  = look;
    assign ctrl.upd   = upd;
    assign ctrl.shift = shift_w[i];

    if (i == 0) begin : g_top
      assign prev_key  = key_q;
      assign prev_used = 1'b1;
    end else begin : g_mid
      assign prev_key  = key_w[i-1];
      assign prev_used = used_w[i-1];
    end

    mtfl_cell #(
      .KW  (KW),
      .IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cmp_key_i   (key_q),
      .rank_i      (rank_q),
      .prev_key_i  (prev_key),
      .prev_used_i (prev_used),
      .key_o       (key_w[i]),
      .used_o      (used_w[i]),
      .stat_o      (stat_w[i]),
      .rd_key_o    (rd_key_w[i])
    );

    assign match_w[i] = stat_w[i].match;
    assign hit_w[i]   = stat_w[i].hit;
    // found key: ranks 0..pos move down; new key: every rank moves down
    assign shift_w[i] = !found || (IDX_W'(i) <= pos);
  end

  // keys are distinct, so the match vector is one-hot or empty
  always_comb begin
    pos    = '0;
    rd_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_w[i]) pos = pos | IDX_W'(i);
      rd_key = rd_key | rd_key_w[i];
    end
  end

  assign found = |match_w;
  assign full  = (count_q == CNT_W'(CAPACITY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (upd && !found && !full) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (apply_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      if (func_q == mtfl_pkg::FUNC_READ) begin
        out_o.was_present <= 1'b0;
        out_o.old_rank    <= '0;
        out_o.evicted     <= 1'b0;
        out_o.key_out     <= mtfl_pkg::KEY_W'(rd_key);
        out_o.read_valid  <= |hit_w;
        out_o.entry_count <= mtfl_pkg::COUNT_W'(count_q);
      end else begin
        out_o.was_present <= found;
        out_o.old_rank    <= found ? mtfl_pkg::RANK_W'(pos) : '0;
        out_o.evicted     <= !found && full;
        out_o.key_out     <= (!found && full) ?
                             mtfl_pkg::KEY_W'(key_w[CAPACITY-1]) : '0;
        out_o.read_valid  <= 1'b0;
        out_o.entry_count <= (!found && !full) ?
                             mtfl_pkg::COUNT_W'(count_q + CNT_W'(1)) :
                             mtfl_pkg::COUNT_W'(count_q);
      end
    end
  end

  assign out_o.valid = out_valid_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_w) == int'(count_q))
    else $error("used bits disagree with entry count");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mtfl_pkg::ST_APPLY) |-> $onehot0(match_w))
    else $error("touched key found at more than one rank");

  a_read_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mtfl_pkg::ST_APPLY) |-> $onehot0(hit_w))
    else $error("read selected more than one rank");

endmodule

// ===== tb/tb_move_to_front_recency_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_move_to_front_recency_list_unit: self-checking bench for the recency list
// Drives touch and read requests through the request channel, keeps a shadow
// copy of the ordered key list, and checks every result beat field by field.
// Runs four traffic phases with different sender and receiver idle rates.
// ----------------------------------------------------------------------------
module tb_move_to_front_recency_list_unit;

  localparam int  LIST_DEPTH   = 64;
  localparam int  NAME_LETTERS = 10;
  localparam int  KEY_POOL_N   = 72;   // a bit above depth so the list overflows
  localparam int  RANDOM_ITEMS = 170;  // per phase
  localparam int  DRAIN_SLACK  = 8;    // cycles past the last result
  localparam int  STALL_LIMIT  = 2000;

  typedef struct packed {
    logic                        func;
    logic [mtfl_pkg::KEY_W-1:0]  name_key;
    logic [mtfl_pkg::RANK_W-1:0] rank;
  } mtf_req_t;

  typedef struct packed {
    logic                         was_present;
    logic [mtfl_pkg::RANK_W-1:0]  old_rank;
    logic                         evicted;
    logic [mtfl_pkg::KEY_W-1:0]   key_out;
    logic                         read_valid;
    logic [mtfl_pkg::COUNT_W-1:0] entry_count;
  } mtf_result_t;

  logic clk_i;
  logic rst_ni;

  mtfl_in_if  req_if ();
  mtfl_out_if res_if ();

  move_to_front_recency_list_unit #(
    .CAPACITY   (LIST_DEPTH),
    .NAME_CHARS (NAME_LETTERS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow list
  logic [mtfl_pkg::KEY_W-1:0] shadow_keys [LIST_DEPTH];
  int                         shadow_count;

  mtf_req_t    pending_reqs [$];
  mtf_result_t expected_results [$];
  logic [mtfl_pkg::KEY_W-1:0] key_pool [KEY_POOL_N];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  beats_queued;
  int  beats_sent;
  int  idle_cycles;
  int  error_count;
  int  n_touch, n_hit, n_evict, n_read, n_read_valid, n_results;
  bit  req_accepted;

  // Touch moves or inserts the key at rank 0; read leaves the list untouched.
  function automatic mtf_result_t apply_request(mtf_req_t r);
    mtf_result_t res;
    bit          hit;
    int          pos;
    int          top;
    res = '0;
    hit = 1'b0;
    pos = 0;
    if (r.func == mtfl_pkg::FUNC_READ) begin
      n_read++;
      if (int'(r.rank) < shadow_count) begin
        res.read_valid = 1'b1;
        res.key_out    = shadow_keys[r.rank];
        n_read_valid++;
      end
    end else begin
      n_touch++;
      for (int i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_keys[i] == r.name_key) begin
          hit = 1'b1;
          pos = i;
        end
      end
      if (hit) begin
        res.was_present = 1'b1;
        res.old_rank    = mtfl_pkg::RANK_W'(pos);
        top             = pos;
        n_hit++;
      end else if (shadow_count == LIST_DEPTH) begin
        res.evicted = 1'b1;
        res.key_out = shadow_keys[LIST_DEPTH-1];
        top         = LIST_DEPTH - 1;
        n_evict++;
      end else begin
        top = shadow_count;
        shadow_count++;
      end
      for (int i = top; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
      shadow_keys[0] = r.name_key;
    end
    res.entry_count = mtfl_pkg::COUNT_W'(shadow_count);
    return res;
  endfunction

  function automatic logic [mtfl_pkg::KEY_W-1:0] random_key();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[mtfl_pkg::KEY_W-1:0];
  endfunction

  function automatic mtf_req_t random_request();
    mtf_req_t r;
    int       pick;
    r.func     = mtfl_pkg::FUNC_TOUCH;
    r.rank     = mtfl_pkg::RANK_W'($urandom_range(0, 63));
    r.name_key = random_key();
    pick       = $urandom_range(0, 99);
    if (pick < 22) begin
      r.func = mtfl_pkg::FUNC_READ;
    end else if (pick < 80) begin
      r.name_key = key_pool[$urandom_range(0, KEY_POOL_N-1)];
    end else if (pick < 84) begin
      r.name_key = '0;
    end
    // otherwise a fresh random key, almost surely new
    return r;
  endfunction

  task automatic queue_request(logic func, logic [mtfl_pkg::KEY_W-1:0] key, int rank);
    mtf_req_t r;
    r.func     = func;
    r.name_key = key;
    r.rank     = mtfl_pkg::RANK_W'(rank);
    pending_reqs.push_back(r);
    beats_queued++;
  endtask

  task automatic wait_drained();
    while (beats_sent != beats_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic report_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
    end
  endtask

  // Driver: new beat at the falling edge once the previous one was taken.
  always @(negedge clk_i) begin : req_driver
    mtf_req_t nxt;
    if (rst_ni) begin
      if (!req_if.valid || req_accepted) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.func     <= nxt.func;
          req_if.name_key <= nxt.name_key;
          req_if.rank     <= nxt.rank;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on request beats, check on result beats.
  always @(posedge clk_i) begin : beat_monitor
    mtf_req_t    r;
    mtf_result_t got;
    mtf_result_t want;
    if (rst_ni) begin
      req_accepted <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        r.func     = req_if.func;
        r.name_key = req_if.name_key;
        r.rank     = req_if.rank;
        expected_results.push_back(apply_request(r));
        beats_sent++;
      end
      if (res_if.valid && res_if.ready) begin
        n_results++;
        got.was_present = res_if.was_present;
        got.old_rank    = res_if.old_rank;
        got.evicted     = res_if.evicted;
        got.key_out     = res_if.key_out;
        got.read_valid  = res_if.read_valid;
        got.entry_count = res_if.entry_count;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected, actual %0h", $time, got);
        end else begin
          want = expected_results.pop_front();
          report_field("was_present", 64'(want.was_present), 64'(got.was_present));
          report_field("old_rank",    64'(want.old_rank),    64'(got.old_rank));
          report_field("evicted",     64'(want.evicted),     64'(got.evicted));
          report_field("key_out",     64'(want.key_out),     64'(got.key_out));
          report_field("read_valid",  64'(want.read_valid),  64'(got.read_valid));
          report_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
        end
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [mtfl_pkg::KEY_W-1:0] odd_codes;
    req_if.valid    = 1'b0;
    req_if.func     = mtfl_pkg::FUNC_TOUCH;
    req_if.name_key = '0;
    req_if.rank     = '0;
    res_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    req_accepted    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    beats_queued    = 0;
    beats_sent      = 0;
    idle_cycles     = 0;
    error_count     = 0;
    shadow_count    = 0;
    n_touch = 0; n_hit = 0; n_evict = 0; n_read = 0; n_read_valid = 0; n_results = 0;
    for (int i = 0; i < LIST_DEPTH; i++) shadow_keys[i] = '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = random_key();
    // letter codes 27..31, beyond the alphabet
    for (int c = 0; c < NAME_LETTERS; c++) odd_codes[5*c +: 5] = 5'(27 + c % 5);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (ph == 0) begin
        queue_request(mtfl_pkg::FUNC_READ,  '0, 0);   // read on empty list
        queue_request(mtfl_pkg::FUNC_TOUCH, '0, 63);  // zero is an ordinary key
        queue_request(mtfl_pkg::FUNC_TOUCH, '1, 0);
        queue_request(mtfl_pkg::FUNC_TOUCH, mtfl_pkg::KEY_W'(1), 0);
        queue_request(mtfl_pkg::FUNC_TOUCH, odd_codes, 0);
        queue_request(mtfl_pkg::FUNC_TOUCH, '0, 0);   // hit at the bottom
        queue_request(mtfl_pkg::FUNC_TOUCH, '0, 0);   // hit at the top
        queue_request(mtfl_pkg::FUNC_TOUCH, '1, 0);   // hit at the bottom again
        for (int k = 0; k < 5; k++) queue_request(mtfl_pkg::FUNC_READ, '1, k);
        queue_request(mtfl_pkg::FUNC_READ,  '0, 63);  // past the entry count
        queue_request(mtfl_pkg::FUNC_TOUCH, mtfl_pkg::KEY_W'(1), 5);
        queue_request(mtfl_pkg::FUNC_READ,  '1, 3);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) pending_reqs.push_back(random_request());
      beats_queued += RANDOM_ITEMS;
      // full list by now: dump every rank top to bottom
      if (ph == 2) begin
        for (int k = 0; k < LIST_DEPTH; k++) queue_request(mtfl_pkg::FUNC_READ, '0, k);
      end
      // sender holds off here until every result is back
      wait_drained();
    end

    if (expected_results.size() != 0) error_count++;
    $display("Covered %0d touches (%0d hits, %0d evictions) and %0d reads (%0d in range),",
             n_touch, n_hit, n_evict, n_read, n_read_valid);
    $display("%0d results checked over four idle/stall phases, %0d mismatches.",
             n_results, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== move_to_front_recency_list_unit.f =====
rtl/core/mtfl_pkg.sv
rtl/core/mtfl_in_if.sv
rtl/core/mtfl_out_if.sv
rtl/core/mtfl_cell.sv
rtl/core/move_to_front_recency_list_unit.sv
tb/tb_move_to_front_recency_list_unit.sv
